// ===== sv/lzd_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, state encoding and controller/datapath bundles for the LZ77 token decoder.
package lzd_pkg;

    localparam int SHIFT_W = 12;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_COPY,
        S_LIT,
        S_BAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic start;
        logic read;
        logic copy;
        logic lit;
        logic bad;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic len_zero;
        logic eom;
        logic last_copy;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== sv/lzd_tok_if.sv =====
`timescale 1ns / 1ps
// Token channel: valid/ready handshake carrying one LZ77 token per word.
interface lzd_tok_if
    import lzd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               new_message;
    logic [SHIFT_W-1:0] shift;
    logic [LEN_W-1:0]   length;
    logic [BYTE_W-1:0]  letter;
    logic               end_of_message;

    modport source (
        output valid, new_message, shift, length, letter, end_of_message,
        input  ready
    );
    modport sink (
        input  valid, new_message, shift, length, letter, end_of_message,
        output ready
    );
endinterface

// ===== sv/lzd_out_if.sv =====
`timescale 1ns / 1ps
// Byte channel: valid/ready handshake carrying one decoded byte per word.
interface lzd_out_if
    import lzd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              bad_token;

    modport source (
        output valid, out_byte, last, bad_token,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last, bad_token,
        output ready
    );
endinterface

// ===== sv/lzd_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine sequencing token check, history copy, literal output and bad-token output.
module lzd_ctrl
    import lzd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tok_valid,
    output logic    o_tok_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_tok_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.bad)           n_state = S_BAD;
                else if (!i_sts.len_zero) n_state = S_READ;
                else if (!i_sts.eom)      n_state = S_LIT;
                else                      n_state = S_IDLE;
            end
            S_READ: begin
                n_state = S_COPY;
            end
            S_COPY: begin
                if (i_sts.out_free) begin
                    if (!i_sts.last_copy) n_state = S_READ;
                    else if (!i_sts.eom)  n_state = S_LIT;
                    else                  n_state = S_IDLE;
                end
            end
            S_LIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_BAD: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_tok_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_tok_ready  = 1'b1;
                o_cmd.accept = i_tok_valid;
            end
            S_CHECK: o_cmd.start = 1'b1;
            S_READ:  o_cmd.read  = 1'b1;
            S_COPY:  o_cmd.copy  = i_sts.out_free;
            S_LIT:   o_cmd.lit   = i_sts.out_free;
            S_BAD:   o_cmd.bad   = i_sts.out_free;
            default: o_cmd       = '0;
        endcase
    end

endmodule

// ===== sv/lzd_dp.sv =====
`timescale 1ns / 1ps
// Datapath: history memory, ring pointers, fill count, token check and output register.
module lzd_dp
    import lzd_pkg::*;
#(
    parameter int WINDOW  = 2048,
    parameter int MAX_LEN = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_new_message,
    input  logic [SHIFT_W-1:0] i_shift,
    input  logic [LEN_W-1:0]   i_length,
    input  logic [BYTE_W-1:0]  i_letter,
    input  logic               i_end_of_message,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_out_last,
    output logic               o_out_bad
);

    localparam int WP_W   = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int CW     = ((FILL_W > SHIFT_W) ? FILL_W : SHIFT_W) + 1;
    localparam logic [CW-1:0]     WIN_C  = CW'(WINDOW);
    localparam logic [WP_W-1:0]   WP_TOP = WP_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_LEN);

    logic [BYTE_W-1:0]  r_mem [WINDOW];
    logic [BYTE_W-1:0]  r_rdata;
    logic [WP_W-1:0]    r_wp;
    logic [WP_W-1:0]    r_rd;
    logic [FILL_W-1:0]  r_fill;
    logic [SHIFT_W-1:0] r_shift;
    logic [LEN_W-1:0]   r_cnt;
    logic [BYTE_W-1:0]  r_letter;
    logic               r_eom;
    logic               r_ovalid;
    logic [BYTE_W-1:0]  r_obyte;
    logic               r_olast;
    logic               r_obad;

    logic [CW-1:0]      w_shift_c;
    logic [CW-1:0]      w_wp_c;
    logic [CW-1:0]      w_rd_c;
    logic               w_we;
    logic [BYTE_W-1:0]  w_wdata;
    logic               w_out_free;

    assign w_shift_c  = CW'(r_shift);
    assign w_wp_c     = CW'(r_wp);
    assign w_rd_c     = (w_wp_c >= w_shift_c) ? (w_wp_c - w_shift_c)
                                              : (w_wp_c + WIN_C - w_shift_c);
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_we       = i_cmd.copy || i_cmd.lit;
    assign w_wdata    = i_cmd.copy ? r_rdata : r_letter;

    always_comb begin
        o_sts.bad       = (r_cnt != '0) &&
                          ((r_shift == '0) || (w_shift_c > CW'(r_fill)) ||
                           (w_shift_c > WIN_C) || (r_cnt > LEN_MAX));
        o_sts.len_zero  = (r_cnt == '0);
        o_sts.eom       = r_eom;
        o_sts.last_copy = (r_cnt == LEN_W'(1));
        o_sts.out_free  = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_wp] <= w_wdata;
        if (i_cmd.read) r_rdata <= r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_shift  <= i_shift;
            r_cnt    <= i_length;
            r_letter <= i_letter;
            r_eom    <= i_end_of_message;
        end
        if (i_cmd.start) r_rd <= WP_W'(w_rd_c);
        if (i_cmd.copy) begin
            r_rd  <= (r_rd == WP_TOP) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.copy || i_cmd.lit || i_cmd.bad) begin
            r_obyte <= i_cmd.copy ? r_rdata : (i_cmd.lit ? r_letter : '0);
            r_olast <= i_cmd.bad || i_cmd.lit || (r_eom && (r_cnt == LEN_W'(1)));
            r_obad  <= i_cmd.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.accept && i_new_message) begin
                r_fill <= '0;
            end else if (w_we && (r_fill != FILL_MAX)) begin
                r_fill <= r_fill + 1'b1;
            end
            if (w_we) r_wp <= (r_wp == WP_TOP) ? '0 : r_wp + 1'b1;
            if (i_cmd.copy || i_cmd.lit || i_cmd.bad) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_out_last  = r_olast;
    assign o_out_bad   = r_obad;

endmodule

// ===== sv/lz77_token_decoder.sv =====
`timescale 1ns / 1ps
// LZ77 token decoder top level: controller, datapath and channel wiring.
//
//  channel  | dir | word                                               | accepted when
//  ---------+-----+----------------------------------------------------+--------------
//  i_tok    | in  | new_message, shift, length, letter, end_of_message | valid & ready
//  o_out    | out | out_byte, last, bad_token                          | valid & ready
//
// A token is accepted in S_IDLE and checked in S_CHECK, then each copied byte goes
// through S_READ (registered history read) and S_COPY (write and output load), and
// the literal through S_LIT; a rejected token goes through S_BAD instead.
// Each copied byte is read from the history into a register before it is written.
// Reset is synchronous, active low; history contents are not cleared.
// A held output word stalls the sequencer only when the next byte is due.
module lz77_token_decoder
    import lzd_pkg::*;
#(
    parameter int WINDOW  = 2048,
    parameter int MAX_LEN = 63
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lzd_tok_if.sink  i_tok,
    lzd_out_if.source o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lzd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (i_tok.valid),
        .o_tok_ready (i_tok.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lzd_dp #(
        .WINDOW  (WINDOW),
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_new_message    (i_tok.new_message),
        .i_shift          (i_tok.shift),
        .i_length         (i_tok.length),
        .i_letter         (i_tok.letter),
        .i_end_of_message (i_tok.end_of_message),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_out_byte       (o_out.out_byte),
        .o_out_last       (o_out.last),
        .o_out_bad        (o_out.bad_token)
    );

endmodule

// ===== sv/lzd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the LZ77 token decoder, bound to the top level.
module lzd_checker
    import lzd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_tok_valid,
    input logic              i_tok_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_out_byte,
    input logic              i_out_last,
    input logic              i_out_bad
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_bad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_bad) |-> i_out_last)
        else $error("bad token word not marked last");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_bad) |-> (i_out_byte == '0))
        else $error("bad token word carries a nonzero byte");

    a_one_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok_valid && i_tok_ready) |=> !i_tok_ready)
        else $error("token taken while previous one still in work");

endmodule

bind lz77_token_decoder lzd_checker u_lzd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_tok_valid (i_tok.valid),
    .i_tok_ready (i_tok.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last),
    .i_out_bad   (o_out.bad_token)
);

// ===== sim/lzd_byte_checker.sv =====
`timescale 1ns / 1ps
// Byte channel checker: predicts decoded words from accepted tokens and compares them.
module lzd_byte_checker
    import lzd_pkg::*;
#(
    parameter int WINDOW  = 2048,
    parameter int MAX_LEN = 63
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lzd_tok_if   i_tok,
    lzd_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              bad_token;
    } t_byte_word;

    logic [BYTE_W-1:0]         history [WINDOW];
    logic [$clog2(WINDOW)-1:0] wr_pos;
    logic [$clog2(WINDOW):0]   fill;
    t_byte_word                decoded_q [$];
    int                        fail_cnt = 0;

    task automatic store_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        t_byte_word w;
        history[wr_pos] = b;
        wr_pos = (wr_pos == WINDOW - 1) ? '0 : wr_pos + 1'b1;
        if (fill < WINDOW)
            fill = fill + 1'b1;
        w.out_byte  = b;
        w.last      = is_last;
        w.bad_token = 1'b0;
        decoded_q.push_back(w);
    endtask

    task automatic decode_token(input logic nm, input logic [SHIFT_W-1:0] sh,
                                input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] lit,
                                input logic eom);
        t_byte_word w;
        int         rd;
        int         i;
        if (nm)
            fill = '0;
        if (len != 0 && (sh == 0 || sh > fill || sh > WINDOW || len > MAX_LEN)) begin
            w.out_byte  = '0;
            w.last      = 1'b1;
            w.bad_token = 1'b1;
            decoded_q.push_back(w);
        end else begin
            for (i = 0; i < len; i++) begin
                rd = int'(wr_pos) - int'(sh);
                if (rd < 0)
                    rd += WINDOW;
                store_byte(history[rd[$clog2(WINDOW)-1:0]], eom && (i == len - 1));
            end
            if (!eom)
                store_byte(lit, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        t_byte_word exp_w;
        t_byte_word act_w;
        if (!i_rst_n) begin
            wr_pos = '0;
            fill   = '0;
            decoded_q.delete();
        end else begin
            if (i_tok.valid && i_tok.ready)
                decode_token(i_tok.new_message, i_tok.shift, i_tok.length, i_tok.letter,
                             i_tok.end_of_message);
            if (i_out.valid && i_out.ready) begin
                act_w.out_byte  = i_out.out_byte;
                act_w.last      = i_out.last;
                act_w.bad_token = i_out.bad_token;
                if (decoded_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("unexpected word: byte %02h last %b bad %b",
                                 act_w.out_byte, act_w.last, act_w.bad_token);
                    fail_cnt++;
                end else begin
                    exp_w = decoded_q.pop_front();
                    if (act_w.out_byte !== exp_w.out_byte || act_w.last !== exp_w.last ||
                        act_w.bad_token !== exp_w.bad_token) begin
                        if (fail_cnt < 10)
                            $display({"mismatch: expected byte %02h last %b bad %b, ",
                                      "got byte %02h last %b bad %b"},
                                     exp_w.out_byte, exp_w.last, exp_w.bad_token,
                                     act_w.out_byte, act_w.last, act_w.bad_token);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending    <= decoded_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, token stimulus, byte channel back-pressure and verdict.
module tb;
    import lzd_pkg::*;

    localparam int WINDOW     = 2048;
    localparam int MAX_LEN    = 63;
    localparam int N_RANDOM   = 335;
    localparam int LONG_HOLD  = 400;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN      = 200;

    typedef enum int {
        RX_FREE,
        RX_HALF,
        RX_SPARSE
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    logic hold_req;
    int   msg_fill;
    int   burst_left;
    int   nm_pct;

    lzd_tok_if tok_ch ();
    lzd_out_if byte_ch ();

    lz77_token_decoder #(
        .WINDOW (WINDOW),
        .MAX_LEN(MAX_LEN)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tok  (tok_ch),
        .o_out  (byte_ch)
    );

    lzd_byte_checker #(
        .WINDOW (WINDOW),
        .MAX_LEN(MAX_LEN)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tok_ch),
        .i_out       (byte_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic pause_sender(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            tok_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_token(input logic nm, input logic [SHIFT_W-1:0] sh,
                              input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] lit,
                              input logic eom);
        @(negedge i_clk);
        tok_ch.valid          <= 1'b1;
        tok_ch.new_message    <= nm;
        tok_ch.shift          <= sh;
        tok_ch.length         <= len;
        tok_ch.letter         <= lit;
        tok_ch.end_of_message <= eom;
        do begin
            @(posedge i_clk);
        end while (!tok_ch.ready);
    endtask

    // keeps track of the usable history so that most tokens are well formed
    task automatic issue(input logic nm, input logic [SHIFT_W-1:0] sh,
                         input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] lit,
                         input logic eom);
        if (nm)
            msg_fill = 0;
        if (len == 0 || !(sh == 0 || sh > msg_fill || sh > WINDOW)) begin
            msg_fill += len + (eom ? 0 : 1);
            if (msg_fill > WINDOW)
                msg_fill = WINDOW;
        end
        send_token(nm, sh, len, lit, eom);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end
    endtask

    task automatic issue_random();
        int                 r;
        int                 avail;
        logic               nm;
        logic               eom;
        logic [SHIFT_W-1:0] sh;
        logic [LEN_W-1:0]   len;
        nm    = ($urandom_range(0, 99) < nm_pct);
        eom   = ($urandom_range(0, 3) == 0);
        r     = $urandom_range(0, 99);
        avail = nm ? 0 : msg_fill;
        len   = LEN_W'($urandom_range(0, 1) ? $urandom_range(1, 8)
                                            : $urandom_range(1, MAX_LEN));
        sh    = SHIFT_W'($urandom);
        if (r < 3)
            sh = '0;
        else if (r < 8)
            sh = SHIFT_W'($urandom_range(avail + 1, 2 ** SHIFT_W - 1));
        else if (r < 12 || avail == 0)
            len = '0;
        else begin
            case ($urandom_range(0, 3))
                0: sh = SHIFT_W'($urandom_range(1, (avail < int'(len)) ? avail : int'(len)));
                1: sh = SHIFT_W'(avail);
                default: sh = SHIFT_W'($urandom_range(1, avail));
            endcase
        end
        issue(nm, sh, len, BYTE_W'($urandom), eom);
    endtask

    initial begin
        logic held;
        t_rx_mode mode;
        int span;
        held = 1'b0;
        byte_ch.ready = 1'b0;
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                @(negedge i_clk);
                byte_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else begin
                mode = t_rx_mode'($urandom_range(0, 2));
                span = $urandom_range(4, 40);
                repeat (span) begin
                    @(negedge i_clk);
                    case (mode)
                        RX_FREE: byte_ch.ready <= 1'b1;
                        RX_HALF: byte_ch.ready <= 1'($urandom_range(0, 1));
                        default: byte_ch.ready <= ($urandom_range(0, 4) == 0);
                    endcase
                end
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((tok_ch.valid && tok_ch.ready) || (byte_ch.valid && byte_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int k;
        i_rst_n               = 1'b0;
        hold_req              = 1'b0;
        msg_fill              = 0;
        burst_left            = 4;
        nm_pct                = 4;
        tok_ch.valid          = 1'b0;
        tok_ch.new_message    = 1'b0;
        tok_ch.shift          = '0;
        tok_ch.length         = '0;
        tok_ch.letter         = '0;
        tok_ch.end_of_message = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(1'b1, 12'd0,    6'd0,  8'h00, 1'b0);
        issue(1'b0, 12'hFFF,  6'd0,  8'hFF, 1'b0);
        issue(1'b0, 12'd5,    6'd0,  8'h11, 1'b1);   // empty token
        issue(1'b0, 12'd0,    6'd5,  8'h22, 1'b0);   // zero distance
        issue(1'b0, 12'd3,    6'd1,  8'h33, 1'b0);   // before stored history
        issue(1'b0, 12'd2,    6'd1,  8'hA5, 1'b0);
        issue(1'b0, 12'd1,    6'd63, 8'h5A, 1'b0);   // overlapping run
        issue(1'b0, 12'hFFF,  6'd1,  8'h44, 1'b0);   // beyond window
        issue(1'b0, 12'd2048, 6'd63, 8'h55, 1'b0);
        issue(1'b0, 12'd68,   6'd63, 8'hC3, 1'b1);   // whole history
        issue(1'b0, 12'd3,    6'd63, 8'h0F, 1'b1);
        issue(1'b1, 12'd1,    6'd1,  8'h66, 1'b0);   // history gone after new message
        issue(1'b1, 12'd0,    6'd0,  8'h5A, 1'b1);
        issue(1'b0, 12'd0,    6'd0,  8'h80, 1'b0);
        issue(1'b0, 12'd1,    6'd1,  8'h7F, 1'b1);
        issue(1'b0, 12'd2,    6'd2,  8'h01, 1'b0);

        for (k = 0; k < N_RANDOM; k++) begin
            nm_pct = (k >= 60 && k < 170) ? 0 : 4;
            if (k == 100)
                hold_req = 1'b1;
            if (k == 220) begin
                pause_sender(1);
                while (pending != 0) @(negedge i_clk);
            end
            issue_random();
        end

        pause_sender(1);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
